// ----- rtl/pts_pkg.sv -----
`timescale 1ns / 1ps
// Shared types and constants for the priority task scheduler.
// No dependencies; used by the core and by its checker.
package pts_pkg;

    localparam int MAX_TASKS_DEF = 8;

    localparam int FUNC_W  = 4;
    localparam int ID_W    = 6;
    localparam int PRIO_W  = 8;
    localparam int TICKS_W = 32;
    localparam int ST_W    = 3;
    localparam int TOTAL_W = 7;

    localparam logic STATUS_DONE = 1'b0;
    localparam logic STATUS_REJ  = 1'b1;

    typedef enum logic [ST_W-1:0] {
        ST_UNUSED    = 3'd0,
        ST_READY     = 3'd1,
        ST_RUNNING   = 3'd2,
        ST_DELAYED   = 3'd3,
        ST_SUSPENDED = 3'd4
    } slot_st_t;

    typedef enum logic [FUNC_W-1:0] {
        FN_TICK      = 4'd0,
        FN_CREATE    = 4'd1,
        FN_DELETE    = 4'd2,
        FN_SUSPEND   = 4'd3,
        FN_RESUME    = 4'd4,
        FN_YIELD     = 4'd5,
        FN_DELAY     = 4'd6,
        FN_DISPATCH  = 4'd7,
        FN_TASK_DONE = 4'd8,
        FN_QUERY     = 4'd9
    } func_t;

    typedef struct packed {
        slot_st_t             state;
        logic [PRIO_W-1:0]    prio;
        logic [TICKS_W-1:0]   delay;
    } slot_t;

endpackage

// ----- rtl/priority_task_scheduler_core.sv -----
`timescale 1ns / 1ps
// Priority task scheduler: slot table in one synchronous RAM, command sequencer.
// Depends on pts_pkg.
//
//  channel | handshake           | payload
//  --------+---------------------+-------------------------------------------------
//  in      | in_valid / in_stall | func, task_id, priority_req, entry_present,
//          |                     | delay_ticks
//  out     | out_valid/out_stall | status, picked_valid, picked_task,
//          |                     | addressed_state, current_valid, current_id,
//          |                     | ready_total
//
// One word at a time. The slot RAM has one read and one write port; tick, create
// and dispatch sweep it slot by slot.
// Reset clears per-slot valid bits at once, so no clearing pass is needed.
// A new word is taken while the previous result still waits in the output
// register; the sequencer holds in its last state until that register frees.
module priority_task_scheduler_core #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         in_valid,
    output logic                         in_stall,
    input  logic [pts_pkg::FUNC_W-1:0]   func,
    input  logic [pts_pkg::ID_W-1:0]     task_id,
    input  logic [pts_pkg::PRIO_W-1:0]   priority_req,
    input  logic                         entry_present,
    input  logic [pts_pkg::TICKS_W-1:0]  delay_ticks,
    output logic                         out_valid,
    input  logic                         out_stall,
    output logic                         status,
    output logic                         picked_valid,
    output logic [pts_pkg::ID_W-1:0]     picked_task,
    output logic [pts_pkg::ST_W-1:0]     addressed_state,
    output logic                         current_valid,
    output logic [pts_pkg::ID_W-1:0]     current_id,
    output logic [pts_pkg::TOTAL_W-1:0]  ready_total
);

    localparam int IDX_W = (MAX_TASKS > 1) ? $clog2(MAX_TASKS) : 1;
    localparam int CNT_W = $clog2(MAX_TASKS + 1);
    localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(MAX_TASKS - 1);
    localparam logic [pts_pkg::ID_W:0] TASKS_LIM = (pts_pkg::ID_W + 1)'(MAX_TASKS);

    typedef enum logic [6:0] {
        S_IDLE  = 7'b0000001,
        S_START = 7'b0000010,
        S_SCAN  = 7'b0000100,
        S_PICK  = 7'b0001000,
        S_MOD   = 7'b0010000,
        S_FETCH = 7'b0100000,
        S_LAST  = 7'b1000000
    } fsm_t;

    fsm_t state_reg, state_next;

    logic [pts_pkg::FUNC_W-1:0]  func_reg;
    logic [pts_pkg::ID_W-1:0]    id_reg;
    logic [pts_pkg::PRIO_W-1:0]  prio_reg;
    logic                        entry_reg;
    logic [pts_pkg::TICKS_W-1:0] ticks_reg;

    logic [IDX_W-1:0] ptr_reg, ptr_next;
    logic [IDX_W-1:0] mod_idx_reg, mod_idx_next;
    logic [IDX_W-1:0] best_idx_reg, best_idx_next;
    logic [pts_pkg::PRIO_W-1:0]  best_prio_reg, best_prio_next;
    logic [pts_pkg::TICKS_W-1:0] best_delay_reg, best_delay_next;
    logic found_reg, found_next;
    logic cur_valid_reg, cur_valid_next;
    logic [IDX_W-1:0] cur_idx_reg, cur_idx_next;
    logic [CNT_W-1:0] ready_cnt_reg, ready_cnt_next;
    logic st_reg, st_next;
    logic pick_v_reg, pick_v_next;
    logic [IDX_W-1:0] pick_idx_reg, pick_idx_next;

    logic                         out_valid_reg;
    logic                         status_reg;
    logic                         picked_valid_reg;
    logic [pts_pkg::ID_W-1:0]     picked_task_reg;
    logic [pts_pkg::ST_W-1:0]     addressed_state_reg;
    logic                         current_valid_reg;
    logic [pts_pkg::ID_W-1:0]     current_id_reg;
    logic [pts_pkg::TOTAL_W-1:0]  ready_total_reg;

    pts_pkg::slot_t mem [MAX_TASKS];
    logic [MAX_TASKS-1:0] vld_reg;
    pts_pkg::slot_t rd_data_reg;
    logic rd_vld_reg;
    pts_pkg::slot_t rd_entry;

    logic [IDX_W-1:0] rd_addr;
    logic [IDX_W-1:0] wr_addr;
    logic             wr_en;
    pts_pkg::slot_t   wr_data;
    logic             old_rdy;
    logic             new_rdy;
    logic             out_load;
    logic             in_range;
    logic [IDX_W-1:0] id_idx;
    logic             accept;
    logic             scan_last;
    logic             scan_hit;

    assign in_stall = (state_reg != S_IDLE);
    assign accept   = in_valid && !in_stall;
    assign in_range = ({1'b0, id_reg} < TASKS_LIM);
    assign id_idx   = id_reg[IDX_W-1:0];
    assign rd_entry = rd_vld_reg ? rd_data_reg : '0;
    assign scan_last = (ptr_reg == LAST_IDX);
    assign scan_hit = (rd_entry.state == pts_pkg::ST_READY) &&
                      (!found_reg || (rd_entry.prio > best_prio_reg));

    // slot RAM with a registered read port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data_reg <= mem[rd_addr];
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            vld_reg    <= '0;
            rd_vld_reg <= 1'b0;
        end
        else
        begin
            if (wr_en)
            begin
                vld_reg[wr_addr] <= 1'b1;
            end
            rd_vld_reg <= vld_reg[rd_addr];
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            func_reg  <= func;
            id_reg    <= task_id;
            prio_reg  <= priority_req;
            entry_reg <= entry_present;
            ticks_reg <= delay_ticks;
        end
        mod_idx_reg    <= mod_idx_next;
        best_idx_reg   <= best_idx_next;
        best_prio_reg  <= best_prio_next;
        best_delay_reg <= best_delay_next;
    end

    always_comb
    begin
        state_next      = state_reg;
        ptr_next        = ptr_reg;
        mod_idx_next    = mod_idx_reg;
        best_idx_next   = best_idx_reg;
        best_prio_next  = best_prio_reg;
        best_delay_next = best_delay_reg;
        found_next      = found_reg;
        cur_valid_next  = cur_valid_reg;
        cur_idx_next    = cur_idx_reg;
        ready_cnt_next  = ready_cnt_reg;
        st_next         = st_reg;
        pick_v_next     = pick_v_reg;
        pick_idx_next   = pick_idx_reg;
        rd_addr         = id_idx;
        wr_en           = 1'b0;
        wr_addr         = ptr_reg;
        wr_data         = rd_entry;
        old_rdy         = 1'b0;
        new_rdy         = 1'b0;
        out_load        = 1'b0;

        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    state_next = S_START;
                end
            end
            S_START:
            begin
                st_next       = pts_pkg::STATUS_REJ;
                pick_v_next   = 1'b0;
                pick_idx_next = '0;
                ptr_next      = '0;
                found_next    = 1'b0;
                state_next    = S_FETCH;
                unique case (func_reg) inside
                    pts_pkg::FN_TICK:
                    begin
                        st_next    = pts_pkg::STATUS_DONE;
                        rd_addr    = '0;
                        state_next = S_SCAN;
                    end
                    pts_pkg::FN_CREATE:
                    begin
                        if (entry_reg)
                        begin
                            rd_addr    = '0;
                            state_next = S_SCAN;
                        end
                    end
                    pts_pkg::FN_DISPATCH:
                    begin
                        if (!cur_valid_reg)
                        begin
                            rd_addr    = '0;
                            state_next = S_SCAN;
                        end
                    end
                    pts_pkg::FN_DELETE, pts_pkg::FN_SUSPEND, pts_pkg::FN_RESUME:
                    begin
                        if (in_range)
                        begin
                            rd_addr      = id_idx;
                            mod_idx_next = id_idx;
                            state_next   = S_MOD;
                        end
                    end
                    pts_pkg::FN_YIELD, pts_pkg::FN_TASK_DONE:
                    begin
                        if (cur_valid_reg)
                        begin
                            rd_addr      = cur_idx_reg;
                            mod_idx_next = cur_idx_reg;
                            state_next   = S_MOD;
                        end
                    end
                    pts_pkg::FN_DELAY:
                    begin
                        if (cur_valid_reg && (ticks_reg != '0))
                        begin
                            rd_addr      = cur_idx_reg;
                            mod_idx_next = cur_idx_reg;
                            state_next   = S_MOD;
                        end
                    end
                    pts_pkg::FN_QUERY:
                    begin
                        if (in_range)
                        begin
                            st_next = pts_pkg::STATUS_DONE;
                        end
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_SCAN:
            begin
                rd_addr  = ptr_reg + IDX_W'(1);
                ptr_next = ptr_reg + IDX_W'(1);
                wr_addr  = ptr_reg;
                unique case (func_reg) inside
                    pts_pkg::FN_TICK:
                    begin
                        if ((rd_entry.state == pts_pkg::ST_DELAYED) && (rd_entry.delay != '0))
                        begin
                            wr_en         = 1'b1;
                            wr_data.delay = rd_entry.delay - pts_pkg::TICKS_W'(1);
                            if (rd_entry.delay == pts_pkg::TICKS_W'(1))
                            begin
                                wr_data.state = pts_pkg::ST_READY;
                                new_rdy       = 1'b1;
                            end
                        end
                        if (scan_last)
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    pts_pkg::FN_CREATE:
                    begin
                        if (rd_entry.state == pts_pkg::ST_UNUSED)
                        begin
                            wr_en         = 1'b1;
                            wr_data.state = pts_pkg::ST_READY;
                            wr_data.prio  = prio_reg;
                            wr_data.delay = '0;
                            new_rdy       = 1'b1;
                            st_next       = pts_pkg::STATUS_DONE;
                            pick_v_next   = 1'b1;
                            pick_idx_next = ptr_reg;
                            state_next    = S_FETCH;
                        end
                        else if (scan_last)
                        begin
                            state_next = S_FETCH;
                        end
                    end
                    pts_pkg::FN_DISPATCH:
                    begin
                        if (scan_hit)
                        begin
                            found_next      = 1'b1;
                            best_idx_next   = ptr_reg;
                            best_prio_next  = rd_entry.prio;
                            best_delay_next = rd_entry.delay;
                        end
                        if (scan_last)
                        begin
                            state_next = (found_reg || scan_hit) ? S_PICK : S_FETCH;
                        end
                    end
                    default:
                    begin
                        state_next = S_FETCH;
                    end
                endcase
            end
            S_PICK:
            begin
                wr_en          = 1'b1;
                wr_addr        = best_idx_reg;
                wr_data.state  = pts_pkg::ST_RUNNING;
                wr_data.prio   = best_prio_reg;
                wr_data.delay  = best_delay_reg;
                old_rdy        = 1'b1;
                cur_valid_next = 1'b1;
                cur_idx_next   = best_idx_reg;
                st_next        = pts_pkg::STATUS_DONE;
                pick_v_next    = 1'b1;
                pick_idx_next  = best_idx_reg;
                state_next     = S_FETCH;
            end
            S_MOD:
            begin
                wr_addr    = mod_idx_reg;
                old_rdy    = (rd_entry.state == pts_pkg::ST_READY);
                state_next = S_FETCH;
                unique case (func_reg) inside
                    pts_pkg::FN_DELETE:
                    begin
                        wr_en   = 1'b1;
                        wr_data = '0;
                        st_next = pts_pkg::STATUS_DONE;
                        if (cur_valid_reg && (cur_idx_reg == mod_idx_reg))
                        begin
                            cur_valid_next = 1'b0;
                            cur_idx_next   = '0;
                        end
                    end
                    pts_pkg::FN_SUSPEND:
                    begin
                        if (rd_entry.state != pts_pkg::ST_UNUSED)
                        begin
                            wr_en         = 1'b1;
                            wr_data.state = pts_pkg::ST_SUSPENDED;
                            wr_data.delay = '0;
                            st_next       = pts_pkg::STATUS_DONE;
                            if (cur_valid_reg && (cur_idx_reg == mod_idx_reg))
                            begin
                                cur_valid_next = 1'b0;
                                cur_idx_next   = '0;
                            end
                        end
                    end
                    pts_pkg::FN_RESUME:
                    begin
                        if (rd_entry.state == pts_pkg::ST_SUSPENDED)
                        begin
                            wr_en         = 1'b1;
                            wr_data.state = pts_pkg::ST_READY;
                            new_rdy       = 1'b1;
                            st_next       = pts_pkg::STATUS_DONE;
                        end
                    end
                    pts_pkg::FN_YIELD:
                    begin
                        if (rd_entry.state == pts_pkg::ST_RUNNING)
                        begin
                            wr_en          = 1'b1;
                            wr_data.state  = pts_pkg::ST_READY;
                            new_rdy        = 1'b1;
                            st_next        = pts_pkg::STATUS_DONE;
                            cur_valid_next = 1'b0;
                            cur_idx_next   = '0;
                        end
                    end
                    pts_pkg::FN_DELAY:
                    begin
                        wr_en          = 1'b1;
                        wr_data.state  = pts_pkg::ST_DELAYED;
                        wr_data.delay  = ticks_reg;
                        st_next        = pts_pkg::STATUS_DONE;
                        cur_valid_next = 1'b0;
                        cur_idx_next   = '0;
                    end
                    pts_pkg::FN_TASK_DONE:
                    begin
                        if (rd_entry.state == pts_pkg::ST_RUNNING)
                        begin
                            wr_en         = 1'b1;
                            wr_data.state = pts_pkg::ST_READY;
                            new_rdy       = 1'b1;
                        end
                        st_next        = pts_pkg::STATUS_DONE;
                        cur_valid_next = 1'b0;
                        cur_idx_next   = '0;
                    end
                    default:
                    begin
                    end
                endcase
            end
            S_FETCH:
            begin
                rd_addr    = id_idx;
                state_next = S_LAST;
            end
            S_LAST:
            begin
                rd_addr = id_idx;
                if (!out_valid_reg || !out_stall)
                begin
                    out_load   = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (wr_en)
        begin
            ready_cnt_next = ready_cnt_reg + CNT_W'(new_rdy) - CNT_W'(old_rdy);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            ptr_reg       <= '0;
            found_reg     <= 1'b0;
            cur_valid_reg <= 1'b0;
            cur_idx_reg   <= '0;
            ready_cnt_reg <= '0;
            st_reg        <= pts_pkg::STATUS_REJ;
            pick_v_reg    <= 1'b0;
            pick_idx_reg  <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            ptr_reg       <= ptr_next;
            found_reg     <= found_next;
            cur_valid_reg <= cur_valid_next;
            cur_idx_reg   <= cur_idx_next;
            ready_cnt_reg <= ready_cnt_next;
            st_reg        <= st_next;
            pick_v_reg    <= pick_v_next;
            pick_idx_reg  <= pick_idx_next;
            if (out_load)
            begin
                out_valid_reg <= 1'b1;
            end
            else if (!out_stall)
            begin
                out_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (out_load)
        begin
            status_reg          <= st_reg;
            picked_valid_reg    <= pick_v_reg;
            picked_task_reg     <= pts_pkg::ID_W'(pick_idx_reg);
            addressed_state_reg <= in_range ? rd_entry.state : pts_pkg::ST_UNUSED;
            current_valid_reg   <= cur_valid_reg;
            current_id_reg      <= pts_pkg::ID_W'(cur_idx_reg);
            ready_total_reg     <= pts_pkg::TOTAL_W'(ready_cnt_reg);
        end
    end

    assign out_valid       = out_valid_reg;
    assign status          = status_reg;
    assign picked_valid    = picked_valid_reg;
    assign picked_task     = picked_task_reg;
    assign addressed_state = addressed_state_reg;
    assign current_valid   = current_valid_reg;
    assign current_id      = current_id_reg;
    assign ready_total     = ready_total_reg;

endmodule

// ----- rtl/pts_checker.sv -----
`timescale 1ns / 1ps
// Port-level checker for the scheduler's result channel, bound to the core.
// Depends on pts_pkg and priority_task_scheduler_core.
module pts_checker #(
    parameter int MAX_TASKS = pts_pkg::MAX_TASKS_DEF
) (
    input logic                         clk,
    input logic                         rst_n,
    input logic                         out_valid,
    input logic                         out_stall,
    input logic                         status,
    input logic                         picked_valid,
    input logic [pts_pkg::ID_W-1:0]     picked_task,
    input logic [pts_pkg::ST_W-1:0]     addressed_state,
    input logic                         current_valid,
    input logic [pts_pkg::ID_W-1:0]     current_id,
    input logic [pts_pkg::TOTAL_W-1:0]  ready_total
);

    localparam logic [pts_pkg::TOTAL_W-1:0] TOTAL_LIM = pts_pkg::TOTAL_W'(MAX_TASKS);

    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && out_stall |=> out_valid && $stable(status) && $stable(picked_task)
            && $stable(ready_total) && $stable(current_id))
        else $error("result word changed while stalled");

    a_pick_done: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && picked_valid |-> status == pts_pkg::STATUS_DONE)
        else $error("picked slot reported on a rejected word");

    a_pick_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !picked_valid |-> picked_task == '0)
        else $error("picked_task nonzero without picked_valid");

    a_cur_zero: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !current_valid |-> current_id == '0)
        else $error("current_id nonzero without current task");

    a_ready_lim: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid |-> (ready_total <= TOTAL_LIM)
            && (addressed_state <= pts_pkg::ST_SUSPENDED))
        else $error("ready count or slot state out of range");

endmodule

bind priority_task_scheduler_core pts_checker #(
    .MAX_TASKS(MAX_TASKS)
) u_pts_checker (
    .clk(clk),
    .rst_n(rst_n),
    .out_valid(out_valid),
    .out_stall(out_stall),
    .status(status),
    .picked_valid(picked_valid),
    .picked_task(picked_task),
    .addressed_state(addressed_state),
    .current_valid(current_valid),
    .current_id(current_id),
    .ready_total(ready_total)
);

// ----- test/priority_task_scheduler_core_tb.sv -----
`timescale 1ns / 1ps
// Testbench for priority_task_scheduler_core: directed and random command words,
// predicted slot-table replies checked in order. Depends on pts_pkg and the core.
module priority_task_scheduler_core_tb;
    import pts_pkg::*;

    localparam int NSLOT       = MAX_TASKS_DEF;
    localparam int CYCLE_LIMIT = 400000;
    localparam int FUNC_TOP    = (1 << FUNC_W) - 1;

    typedef struct packed {
        logic                status;
        logic                picked_valid;
        logic [ID_W-1:0]     picked_task;
        logic [ST_W-1:0]     addressed_state;
        logic                current_valid;
        logic [ID_W-1:0]     current_id;
        logic [TOTAL_W-1:0]  ready_total;
    } reply_t;

    logic                clk;
    logic                rst_n;
    logic                in_valid;
    logic                in_stall;
    logic [FUNC_W-1:0]   func;
    logic [ID_W-1:0]     task_id;
    logic [PRIO_W-1:0]   priority_req;
    logic                entry_present;
    logic [TICKS_W-1:0]  delay_ticks;
    logic                out_valid;
    logic                out_stall;
    logic                status;
    logic                picked_valid;
    logic [ID_W-1:0]     picked_task;
    logic [ST_W-1:0]     addressed_state;
    logic                current_valid;
    logic [ID_W-1:0]     current_id;
    logic [TOTAL_W-1:0]  ready_total;

    slot_st_t            tbl_state [NSLOT];
    logic [PRIO_W-1:0]   tbl_prio [NSLOT];
    logic [TICKS_W-1:0]  tbl_delay [NSLOT];
    logic [ID_W-1:0]     cur_slot;
    bit                  cur_flag;

    reply_t              pending_replies [$];
    int                  err_count;
    int                  cycle_count;
    bit                  src_idle_en;
    bit                  sink_idle_en;
    int                  sink_hold_len;

    priority_task_scheduler_core uut (
        .clk             (clk),
        .rst_n           (rst_n),
        .in_valid        (in_valid),
        .in_stall        (in_stall),
        .func            (func),
        .task_id         (task_id),
        .priority_req    (priority_req),
        .entry_present   (entry_present),
        .delay_ticks     (delay_ticks),
        .out_valid       (out_valid),
        .out_stall       (out_stall),
        .status          (status),
        .picked_valid    (picked_valid),
        .picked_task     (picked_task),
        .addressed_state (addressed_state),
        .current_valid   (current_valid),
        .current_id      (current_id),
        .ready_total     (ready_total)
    );

    initial
    begin
        clk = 1'b0;
        forever #4 clk = ~clk;
    end

    initial
    begin
        cycle_count = 0;
        forever
        begin
            @(posedge clk);
            cycle_count++;
            if (cycle_count > CYCLE_LIMIT)
            begin
                $display("priority_task_scheduler_core_tb failed");
                $finish;
            end
        end
    end

    function automatic reply_t predict_reply(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                                             logic [PRIO_W-1:0] pr, logic en,
                                             logic [TICKS_W-1:0] tk);
        reply_t r;
        bit     in_rng;
        bit     found;
        int     best;
        int     i;
        r = '0;
        r.status = STATUS_REJ;
        in_rng = id < NSLOT;
        found = 1'b0;
        best = 0;
        case (f)
            FN_TICK:
            begin
                for (i = 0; i < NSLOT; i++)
                begin
                    if (tbl_state[i] == ST_DELAYED && tbl_delay[i] != 0)
                    begin
                        tbl_delay[i] = tbl_delay[i] - 1;
                        if (tbl_delay[i] == 0)
                            tbl_state[i] = ST_READY;
                    end
                end
                r.status = STATUS_DONE;
            end
            FN_CREATE:
            begin
                if (en)
                begin
                    for (i = 0; i < NSLOT && !found; i++)
                    begin
                        if (tbl_state[i] == ST_UNUSED)
                        begin
                            found = 1'b1;
                            tbl_state[i] = ST_READY;
                            tbl_prio[i] = pr;
                            tbl_delay[i] = '0;
                            r.picked_valid = 1'b1;
                            r.picked_task = ID_W'(i);
                            r.status = STATUS_DONE;
                        end
                    end
                end
            end
            FN_DELETE:
            begin
                if (in_rng)
                begin
                    tbl_state[id] = ST_UNUSED;
                    tbl_prio[id] = '0;
                    tbl_delay[id] = '0;
                    if (cur_flag && cur_slot == id)
                    begin
                        cur_flag = 1'b0;
                        cur_slot = '0;
                    end
                    r.status = STATUS_DONE;
                end
            end
            FN_SUSPEND:
            begin
                if (in_rng && tbl_state[id] != ST_UNUSED)
                begin
                    tbl_state[id] = ST_SUSPENDED;
                    tbl_delay[id] = '0;
                    if (cur_flag && cur_slot == id)
                    begin
                        cur_flag = 1'b0;
                        cur_slot = '0;
                    end
                    r.status = STATUS_DONE;
                end
            end
            FN_RESUME:
            begin
                if (in_rng && tbl_state[id] == ST_SUSPENDED)
                begin
                    tbl_state[id] = ST_READY;
                    r.status = STATUS_DONE;
                end
            end
            FN_YIELD:
            begin
                if (cur_flag && tbl_state[cur_slot] == ST_RUNNING)
                begin
                    tbl_state[cur_slot] = ST_READY;
                    cur_flag = 1'b0;
                    cur_slot = '0;
                    r.status = STATUS_DONE;
                end
            end
            FN_DELAY:
            begin
                if (tk != 0 && cur_flag)
                begin
                    tbl_delay[cur_slot] = tk;
                    tbl_state[cur_slot] = ST_DELAYED;
                    cur_flag = 1'b0;
                    cur_slot = '0;
                    r.status = STATUS_DONE;
                end
            end
            FN_DISPATCH:
            begin
                if (!cur_flag)
                begin
                    for (i = 0; i < NSLOT; i++)
                    begin
                        if (tbl_state[i] == ST_READY && (!found || tbl_prio[i] > tbl_prio[best]))
                        begin
                            found = 1'b1;
                            best = i;
                        end
                    end
                    if (found)
                    begin
                        tbl_state[best] = ST_RUNNING;
                        cur_slot = ID_W'(best);
                        cur_flag = 1'b1;
                        r.picked_valid = 1'b1;
                        r.picked_task = ID_W'(best);
                        r.status = STATUS_DONE;
                    end
                end
            end
            FN_TASK_DONE:
            begin
                if (cur_flag)
                begin
                    if (tbl_state[cur_slot] == ST_RUNNING)
                        tbl_state[cur_slot] = ST_READY;
                    cur_flag = 1'b0;
                    cur_slot = '0;
                    r.status = STATUS_DONE;
                end
            end
            FN_QUERY:
            begin
                if (in_rng)
                    r.status = STATUS_DONE;
            end
            default:
            begin
            end
        endcase
        for (i = 0; i < NSLOT; i++)
            if (tbl_state[i] == ST_READY)
                r.ready_total++;
        r.addressed_state = in_rng ? tbl_state[id] : ST_UNUSED;
        r.current_valid = cur_flag;
        r.current_id = cur_flag ? cur_slot : '0;
        return r;
    endfunction

    task automatic check_field(string name, logic [31:0] exp_v, logic [31:0] act_v);
        if (act_v !== exp_v)
        begin
            $error("%s: expected %0d, got %0d", name, exp_v, act_v);
            err_count++;
        end
    endtask

    task automatic check_reply();
        reply_t e;
        if (pending_replies.size() == 0)
        begin
            $error("unexpected result word");
            err_count++;
        end
        else
        begin
            e = pending_replies.pop_front();
            check_field("status", e.status, status);
            check_field("picked_valid", e.picked_valid, picked_valid);
            check_field("picked_task", e.picked_task, picked_task);
            check_field("addressed_state", e.addressed_state, addressed_state);
            check_field("current_valid", e.current_valid, current_valid);
            check_field("current_id", e.current_id, current_id);
            check_field("ready_total", e.ready_total, ready_total);
        end
    endtask

    always @(posedge clk)
    begin
        if (rst_n === 1'b1)
        begin
            if (out_valid === 1'b1 && out_stall === 1'b0)
                check_reply();
            if (in_valid === 1'b1 && in_stall === 1'b0)
                pending_replies.push_back(predict_reply(func, task_id, priority_req,
                                                        entry_present, delay_ticks));
        end
    end

    initial
    begin : sink_drive
        int n;
        out_stall <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (sink_hold_len > 0)
            begin
                n = sink_hold_len;
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
                sink_hold_len = 0;
            end
            else if (sink_idle_en && $urandom_range(0, 4) == 0)
            begin
                out_stall <= 1'b1;
                repeat ($urandom_range(1, 6)) @(posedge clk);
                out_stall <= 1'b0;
            end
        end
    end

    task automatic send_word(logic [FUNC_W-1:0] f, logic [ID_W-1:0] id,
                             logic [PRIO_W-1:0] pr, logic en, logic [TICKS_W-1:0] tk);
        func <= f;
        task_id <= id;
        priority_req <= pr;
        entry_present <= en;
        delay_ticks <= tk;
        in_valid <= 1'b1;
        do
            @(posedge clk);
        while (in_stall !== 1'b0);
        if (src_idle_en && $urandom_range(0, 3) == 0)
        begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 6)) @(posedge clk);
        end
    endtask

    task automatic stop_sending();
        in_valid <= 1'b0;
    endtask

    // first edge lets the last accepted word reach the queue
    task automatic wait_drained();
        @(posedge clk);
        while (pending_replies.size() != 0)
            @(posedge clk);
    endtask

    task automatic send_random_cmd();
        int                  sel;
        logic [FUNC_W-1:0]   f;
        logic [ID_W-1:0]     id;
        logic [PRIO_W-1:0]   pr;
        logic                en;
        logic [TICKS_W-1:0]  tk;
        sel = $urandom_range(0, 99);
        if ($urandom_range(0, 15) == 0)
            id = ID_W'($urandom_range(0, 63));
        else
            id = ID_W'($urandom_range(0, NSLOT - 1));
        case ($urandom_range(0, 3))
            0:       pr = '0;
            1:       pr = '1;
            2:       pr = PRIO_W'($urandom_range(100, 101));
            default: pr = PRIO_W'($urandom);
        endcase
        en = ($urandom_range(0, 9) != 0);
        if ($urandom_range(0, 7) == 0)
            tk = $urandom;
        else if ($urandom_range(0, 9) == 0)
            tk = '0;
        else
            tk = TICKS_W'($urandom_range(1, 4));
        if (sel < 20)
            f = FN_TICK;
        else if (sel < 34)
            f = FN_CREATE;
        else if (sel < 40)
            f = FN_DELETE;
        else if (sel < 46)
            f = FN_SUSPEND;
        else if (sel < 52)
            f = FN_RESUME;
        else if (sel < 58)
            f = FN_YIELD;
        else if (sel < 66)
            f = FN_DELAY;
        else if (sel < 80)
            f = FN_DISPATCH;
        else if (sel < 88)
            f = FN_TASK_DONE;
        else if (sel < 96)
            f = FN_QUERY;
        else
            f = FUNC_W'($urandom_range(int'(FN_QUERY) + 1, FUNC_TOP));
        send_word(f, id, pr, en, tk);
    endtask

    task automatic test_directed_basics();
        send_word(FN_QUERY, 0, 0, 1, 0);
        send_word(FN_QUERY, 63, 0, 1, 0);
        send_word(FN_DISPATCH, 0, 0, 1, 0);
        send_word(FN_YIELD, 0, 0, 1, 0);
        send_word(FN_TASK_DONE, 0, 0, 1, 0);
        send_word(FN_DELAY, 0, 0, 1, 5);
        send_word(FN_CREATE, 0, 7, 0, 0);
        send_word(FN_CREATE, 0, 255, 1, 0);
        send_word(FN_CREATE, 0, 0, 1, 0);
        send_word(FN_CREATE, 0, 255, 1, 0);
        send_word(FN_DISPATCH, 0, 0, 1, 0);
        send_word(FN_DISPATCH, 0, 0, 1, 0);
        send_word(FN_DELAY, 0, 0, 1, 0);
        send_word(FN_DELAY, 0, 0, 1, 2);
        send_word(FN_DISPATCH, 2, 0, 1, 0);
        send_word(FN_TICK, 0, 0, 1, 0);
        send_word(FN_TICK, 0, 0, 1, 0);
        send_word(FN_YIELD, 2, 0, 1, 0);
        send_word(FN_SUSPEND, 1, 0, 1, 0);
        send_word(FN_RESUME, 1, 0, 1, 0);
        send_word(FN_RESUME, 1, 0, 1, 0);
        send_word(FN_SUSPEND, 5, 0, 1, 0);
        send_word(FN_SUSPEND, 8, 0, 1, 0);
        send_word(FN_DISPATCH, 0, 0, 1, 0);
        send_word(FN_DELETE, 0, 0, 1, 0);
        send_word(FN_TASK_DONE, 0, 0, 1, 0);
        send_word(FUNC_W'(FUNC_TOP), 3, 0, 1, 0);
        send_word(FN_DELETE, 63, 0, 1, 0);
    endtask

    task automatic test_table_full();
        int i;
        for (i = 0; i < NSLOT; i++)
            send_word(FN_CREATE, 0, PRIO_W'($urandom), 1, 0);
        send_word(FN_DISPATCH, 0, 0, 1, 0);
        send_word(FN_DELAY, 0, 0, 1, '1);
        send_word(FN_TICK, 0, 0, 1, 0);
        send_word(FN_QUERY, 7, 0, 1, 0);
    endtask

    task automatic test_output_backpressure();
        int i;
        sink_hold_len = 300;
        for (i = 0; i < 16; i++)
            send_random_cmd();
    endtask

    task automatic test_drain_pause();
        int i;
        for (i = 0; i < 30; i++)
            send_random_cmd();
        stop_sending();
        wait_drained();
        for (i = 0; i < 10; i++)
            send_random_cmd();
    endtask

    task automatic test_random_mix();
        int i;
        for (i = 0; i < 1450; i++)
        begin
            if (i % 100 == 0)
            begin
                src_idle_en = ($urandom_range(0, 3) != 0);
                sink_idle_en = ($urandom_range(0, 3) != 0);
            end
            if (i % 400 == 399)
            begin
                stop_sending();
                wait_drained();
            end
            send_random_cmd();
        end
    endtask

    task automatic test_full_rate_tail();
        int i;
        src_idle_en = 1'b0;
        sink_idle_en = 1'b0;
        for (i = 0; i < 250; i++)
            send_random_cmd();
    endtask

    initial
    begin : stimulus
        int i;
        err_count = 0;
        sink_hold_len = 0;
        src_idle_en = 1'b1;
        sink_idle_en = 1'b1;
        cur_flag = 1'b0;
        cur_slot = '0;
        for (i = 0; i < NSLOT; i++)
        begin
            tbl_state[i] = ST_UNUSED;
            tbl_prio[i] = '0;
            tbl_delay[i] = '0;
        end
        rst_n <= 1'b0;
        in_valid <= 1'b0;
        func <= FN_TICK;
        task_id <= '0;
        priority_req <= '0;
        entry_present <= 1'b0;
        delay_ticks <= '0;
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_directed_basics();
        test_table_full();
        test_output_backpressure();
        test_drain_pause();
        test_random_mix();
        test_full_rate_tail();

        stop_sending();
        wait_drained();
        repeat (20) @(posedge clk);
        if (err_count == 0)
            $display("priority_task_scheduler_core_tb passed");
        else
            $display("priority_task_scheduler_core_tb failed");
        $finish;
    end

endmodule
